FILE: hdl/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// Depends on nothing; every other file in this folder imports it.
package bole_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  // Operation codes; codes 5 to 7 carry no meaning and are ignored.
  localparam logic [OP_W-1:0] OP_INSERT_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_ITEM = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         position;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] removed_value;
    logic [LEN_W-1:0]         list_length;
  } result_t;

  // Update command from the decision logic to the entry storage.
  typedef struct packed {
    logic insert;
    logic remove;
  } store_cmd_t;

endpackage

FILE: hdl/bounded_ordered_list_engine_top.sv
// Top level of the bounded ordered list engine: request register, length
// register and result register around bole_pick and bole_store. Uses bole_pkg.
//
// The engine holds an ordered list of up to CAPACITY signed 32-bit values,
// slot 0 being the head, and carries out one operation per request word:
// insert at head, remove head, remove tail, remove at an index, or remove the
// first entry equal to a value. A request word is taken at a rising edge where
// start is high and busy is low; busy is set by rst and clears at the first
// edge with rst low, after which a new word can be issued in every cycle.
// Each word yields exactly one result word, shown on result for a single
// cycle with done high, through the request register and then the result
// register. There is no way to hold a result back, so the receiver must
// capture it in that cycle. The work for a word is one pass of logic between
// the request register and the result register; its depth is set by the
// parallel compare across all CAPACITY slots and the priority pick of the first
// match. list_length reports the low five bits of the count of held entries.
module bounded_ordered_list_engine_top #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bole_pkg::request_t request,
  output logic               done,
  output bole_pkg::result_t  result
);
  import bole_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Request stage.
  logic     req_valid;
  request_t req;

  // Length of the list.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [CAPACITY-1:0]      sel;
  logic [CAPACITY-1:0]      hit;
  store_cmd_t               cmd;
  store_cmd_t               cmd_gated;
  logic [STAT_W-1:0]        status_next;
  logic signed [DATA_W-1:0] removed;
  logic [EXT_W-1:0]         len_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      req_valid <= 1'b0;
    end else begin
      busy      <= 1'b0;
      req_valid <= start && !busy;
    end
    if (start && !busy) begin
      req <= request;
    end
  end

  bole_pick #(
    .CAPACITY (CAPACITY)
  ) u_pick (
    .req        (req),
    .count      (count),
    .hit        (hit),
    .sel        (sel),
    .cmd        (cmd),
    .status     (status_next),
    .count_next (count_next)
  );

  // The slots change only when a request word is really in the stage.
  assign cmd_gated.insert = cmd.insert && req_valid;
  assign cmd_gated.remove = cmd.remove && req_valid;

  bole_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .cmd     (cmd_gated),
    .value   (req.item_value),
    .sel     (sel),
    .hit     (hit),
    .removed (removed)
  );

  assign len_ext = EXT_W'(count_next);

  // The length register and the result strobe are control state; the result
  // payload is loaded with each word and needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= req_valid;
      if (req_valid) begin
        count <= count_next;
      end
    end
    if (req_valid) begin
      result.status        <= status_next;
      result.removed_value <= removed;
      result.list_length   <= len_ext[LEN_W-1:0];
    end
  end

endmodule

FILE: hdl/bole_store.sv
// Entry storage of the list engine: the slot registers, the parallel compare
// against the search value, removal read-out and the one-place shifts. Uses bole_pkg.
module bole_store #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  bole_pkg::store_cmd_t               cmd,
  input  logic signed [bole_pkg::DATA_W-1:0] value,
  input  logic [CAPACITY-1:0]                sel,
  output logic [CAPACITY-1:0]                hit,
  output logic signed [bole_pkg::DATA_W-1:0] removed
);
  import bole_pkg::*;

  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]      shift_up;

  // For a one-hot removal select, every slot at or behind it pulls from its successor.
  assign shift_up = ~(sel - CAPACITY'(1));

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      hit[j] = (entries[j] == value);
    end
  end

  always_comb begin
    removed = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (sel[j]) begin
        removed = removed | entries[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      entries[0] <= value;
      for (int j = 1; j < CAPACITY; j++) begin
        entries[j] <= entries[j-1];
      end
    end else if (cmd.remove) begin
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if (shift_up[j]) begin
          entries[j] <= entries[j+1];
        end
      end
    end
  end

endmodule

FILE: hdl/bole_pick.sv
// Decision logic of the list engine: decodes the operation, picks the slot to
// remove as a one-hot select, and forms status and the new length. Uses bole_pkg.
module bole_pick #(
  parameter  int CAPACITY = 16,
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  bole_pkg::request_t            req,
  input  logic [CNT_W-1:0]              count,
  input  logic [CAPACITY-1:0]           hit,
  output logic [CAPACITY-1:0]           sel,
  output bole_pkg::store_cmd_t          cmd,
  output logic [bole_pkg::STAT_W-1:0]   status,
  output logic [CNT_W-1:0]              count_next
);
  import bole_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CMP_W-1:0]    cnt_c;
  logic [CMP_W-1:0]    pos_c;
  logic [CMP_W-1:0]    last_c;
  logic [CAPACITY-1:0] live;
  logic [CAPACITY-1:0] at_pos;
  logic [CAPACITY-1:0] at_tail;
  logic [CAPACITY-1:0] live_hit;
  logic [CAPACITY-1:0] first_hit;
  logic                nonempty;
  logic                full;
  logic                is_remove;

  assign cnt_c    = CMP_W'(count);
  assign pos_c    = CMP_W'(req.position);
  assign last_c   = cnt_c - CMP_W'(1);
  assign nonempty = (count != '0);
  assign full     = (count == CNT_W'(CAPACITY));

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      live[j]    = (CMP_W'(j) < cnt_c);
      at_pos[j]  = (CMP_W'(j) == pos_c);
      at_tail[j] = (CMP_W'(j) == last_c);
    end
  end

  // Only held entries may match; the lowest match wins.
  assign live_hit  = hit & live;
  assign first_hit = live_hit & (~live_hit + CAPACITY'(1));

  always_comb begin
    sel        = '0;
    cmd        = '0;
    status     = ST_NONE;
    count_next = count;
    is_remove  = 1'b0;
    case (req.operation)
      OP_INSERT_HEAD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.insert = 1'b1;
          status     = ST_DONE;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE_HEAD: begin
        is_remove = 1'b1;
        sel       = nonempty ? CAPACITY'(1) : '0;
      end
      OP_REMOVE_TAIL: begin
        is_remove = 1'b1;
        sel       = nonempty ? at_tail : '0;
      end
      OP_REMOVE_AT: begin
        is_remove = 1'b1;
        sel       = (pos_c < cnt_c) ? at_pos : '0;
      end
      OP_REMOVE_ITEM: begin
        is_remove = 1'b1;
        sel       = first_hit;
      end
      default: begin
        is_remove = 1'b0;
      end
    endcase
    if (is_remove && (sel != '0)) begin
      cmd.remove = 1'b1;
      status     = ST_DONE;
      count_next = count - CNT_W'(1);
    end
  end

endmodule
